// ----- rtl/xml_entity_unescape_core_assert.svh -----
// Assertion macros used by the entity decoder's back end (xec_back).
`ifndef XML_ENTITY_UNESCAPE_CORE_ASSERT_SVH
`define XML_ENTITY_UNESCAPE_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define XEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define XEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/xec_pkg.sv -----
`default_nettype none
package xec_pkg;

    localparam int WINDOW  = 12;
    localparam int MAX_RES = WINDOW + 1;
    localparam int CNT_W   = $clog2(WINDOW);
    localparam int LEN_W   = $clog2(WINDOW + 1);
    localparam int EM_W    = $clog2(WINDOW + 2);
    localparam int OC_W    = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LM   = 8'h6D;
    localparam logic [7:0] CH_LP   = 8'h70;
    localparam logic [7:0] CH_LL   = 8'h6C;
    localparam logic [7:0] CH_LT_T = 8'h74;
    localparam logic [7:0] CH_LG   = 8'h67;
    localparam logic [7:0] CH_LQ   = 8'h71;
    localparam logic [7:0] CH_LU   = 8'h75;
    localparam logic [7:0] CH_LO   = 8'h6F;
    localparam logic [7:0] CH_LS   = 8'h73;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    localparam logic [20:0] CP_SAT  = 21'h110000;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } push_t;

    // Returns {is_digit, value} for a decimal or hex digit.
    function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/xec_in_if.sv -----
`default_nettype none
interface xec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/xec_out_if.sv -----
`default_nettype none
interface xec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       run_last;

    modport source (output valid, output plain_byte, output run_last, input ready);
    modport sink (input valid, input plain_byte, input run_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/xec_front.sv -----
`default_nettype none
module xec_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    xec_in_if.sink               text_in,
    output      xec_pkg::in_item_t item,
    output      logic            item_valid,
    input  wire logic            item_pop
);
    import xec_pkg::*;

    in_item_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    // Two-entry queue that decouples the input channel from the engine.
    assign text_in.ready = (cnt_reg != 2'd2);
    assign push          = text_in.valid && text_in.ready;
    assign item_valid    = (cnt_reg != 2'd0);
    assign pop           = item_pop && item_valid;
    assign item          = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{text_byte: text_in.text_byte, text_end: text_in.text_end};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/xec_ofifo.sv -----
`default_nettype none
module xec_ofifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire xec_pkg::push_t push,
    output      logic        space,
    xec_out_if.source        plain_out
);
    import xec_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr;
    logic       rd;

    // Output queue: results wait here while the receiver stalls.
    assign space                = (cnt_reg != 2'd2);
    assign wr                   = push.valid && space;
    assign plain_out.valid      = (cnt_reg != 2'd0);
    assign plain_out.plain_byte = slot_reg[rd_ptr_reg].plain_byte;
    assign plain_out.run_last   = slot_reg[rd_ptr_reg].run_last;
    assign rd                   = plain_out.valid && plain_out.ready;

    always_comb
    begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/xec_back.sv -----
`default_nettype none
`include "xml_entity_unescape_core_assert.svh"
module xec_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire xec_pkg::in_item_t item,
    input  wire logic              item_valid,
    output      logic              item_pop,
    input  wire logic              out_space,
    output      xec_pkg::push_t    push
);
    import xec_pkg::*;

    // Scan queue, entity hold buffer and step control.
    logic [7:0]       pq_reg [WINDOW];
    logic [7:0]       pq_next [WINDOW];
    logic [LEN_W-1:0] pq_len_reg, pq_len_next;
    logic [7:0]       held_reg [WINDOW];
    logic [7:0]       held_next [WINDOW];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_ent_reg, in_ent_next;
    logic             end_reg, end_next;
    logic             busy_reg, busy_next;

    // Running digit parse of the held bytes.
    logic             hex_reg, hex_next;
    logic             dig_reg, dig_next;
    logic             stop_reg, stop_next;
    logic [20:0]      val_reg, val_next;

    // Resolved sequence being emitted.
    logic             em_act_reg, em_act_next;
    logic             em_lit_reg, em_lit_next;
    logic [EM_W-1:0]  em_idx_reg, em_idx_next;
    logic [EM_W-1:0]  em_len_reg, em_len_next;
    logic [7:0]       em_b_reg [4];
    logic [7:0]       em_b_next [4];
    logic [CNT_W-1:0] lit_n_reg, lit_n_next;

    // Result held back until it is known whether it ends the run.
    logic             pend_v_reg, pend_v_next;
    logic [7:0]       pend_b_reg, pend_b_next;
    logic [OC_W-1:0]  ocnt_reg, ocnt_next;

    logic             emit_req;
    logic [7:0]       emit_byte;
    logic             finish;
    logic [7:0]       head;
    logic [7:0]       lit_byte;
    logic [EM_W-1:0]  idx_m1;
    logic             hex_use;
    logic [4:0]       dv;
    logic [24:0]      prod;
    logic             is_amp, is_lt, is_gt, is_quot, is_apos;
    logic             is_num, num_ok;

    assign head   = pq_reg[0];
    assign idx_m1 = em_idx_reg - EM_W'(1);

    // Byte of a literal pass-through at the current emit index.
    always_comb
    begin
        if (em_idx_reg == EM_W'(0))
        begin
            lit_byte = CH_AMP;
        end
        else if (em_idx_reg == EM_W'(lit_n_reg) + EM_W'(1))
        begin
            lit_byte = CH_SEMI;
        end
        else
        begin
            lit_byte = held_reg[idx_m1[CNT_W-1:0]];
        end
    end

    // Name and character reference classification at the closing ';'.
    always_comb
    begin
        is_amp  = (cnt_reg == CNT_W'(3)) && held_reg[0] == CH_LA && held_reg[1] == CH_LM
                  && held_reg[2] == CH_LP;
        is_lt   = (cnt_reg == CNT_W'(2)) && held_reg[0] == CH_LL && held_reg[1] == CH_LT_T;
        is_gt   = (cnt_reg == CNT_W'(2)) && held_reg[0] == CH_LG && held_reg[1] == CH_LT_T;
        is_quot = (cnt_reg == CNT_W'(4)) && held_reg[0] == CH_LQ && held_reg[1] == CH_LU
                  && held_reg[2] == CH_LO && held_reg[3] == CH_LT_T;
        is_apos = (cnt_reg == CNT_W'(4)) && held_reg[0] == CH_LA && held_reg[1] == CH_LP
                  && held_reg[2] == CH_LO && held_reg[3] == CH_LS;
        is_num  = (cnt_reg > CNT_W'(1)) && held_reg[0] == CH_HASH;
        num_ok  = dig_reg && val_reg != 21'd0 && val_reg <= CP_MAX
                  && !(val_reg >= SURR_LO && val_reg <= SURR_HI);
    end

    // Digit accumulation for the byte being held.
    always_comb
    begin
        hex_use = (cnt_reg == CNT_W'(1)) ? (head == CH_LX || head == CH_UX) : hex_reg;
        dv      = digit_val(head, hex_use);
        if (hex_use)
        begin
            prod = {val_reg, 4'd0} + 25'(dv[3:0]);
        end
        else
        begin
            prod = {1'b0, val_reg, 3'd0} + {3'd0, val_reg, 1'b0} + 25'(dv[3:0]);
        end
    end

    always_comb
    begin
        pq_next     = pq_reg;
        pq_len_next = pq_len_reg;
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        in_ent_next = in_ent_reg;
        end_next    = end_reg;
        busy_next   = busy_reg;
        hex_next    = hex_reg;
        dig_next    = dig_reg;
        stop_next   = stop_reg;
        val_next    = val_reg;
        em_act_next = em_act_reg;
        em_lit_next = em_lit_reg;
        em_idx_next = em_idx_reg;
        em_len_next = em_len_reg;
        em_b_next   = em_b_reg;
        lit_n_next  = lit_n_reg;
        pend_v_next = pend_v_reg;
        pend_b_next = pend_b_reg;
        ocnt_next   = ocnt_reg;
        emit_req    = 1'b0;
        emit_byte   = 8'd0;
        finish      = 1'b0;
        item_pop    = 1'b0;
        push        = '0;

        // The engine advances only while the output queue has room.
        if (out_space)
        begin
            if (!busy_reg)
            begin
                if (item_valid)
                begin
                    item_pop    = 1'b1;
                    pq_next[0]  = item.text_byte;
                    pq_len_next = LEN_W'(1);
                    end_next    = item.text_end;
                    busy_next   = 1'b1;
                end
            end
            else if (em_act_reg)
            begin
                emit_req  = 1'b1;
                emit_byte = em_lit_reg ? lit_byte : em_b_reg[em_idx_reg[1:0]];
                if (em_idx_reg == em_len_reg - EM_W'(1))
                begin
                    em_act_next = 1'b0;
                end
                else
                begin
                    em_idx_next = em_idx_reg + EM_W'(1);
                end
            end
            else if (pq_len_reg != LEN_W'(0))
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    pq_next[i] = pq_reg[i + 1];
                end
                pq_len_next = pq_len_reg - LEN_W'(1);
                if (!in_ent_reg)
                begin
                    if (head == CH_AMP)
                    begin
                        in_ent_next = 1'b1;
                        cnt_next    = '0;
                        hex_next    = 1'b0;
                        dig_next    = 1'b0;
                        stop_next   = 1'b0;
                        val_next    = 21'd0;
                    end
                    else
                    begin
                        emit_req  = 1'b1;
                        emit_byte = head;
                    end
                end
                else if (head == CH_SEMI)
                begin
                    // Resolve the held entity into an emit sequence.
                    in_ent_next = 1'b0;
                    cnt_next    = '0;
                    em_act_next = 1'b1;
                    em_idx_next = '0;
                    em_lit_next = 1'b0;
                    lit_n_next  = cnt_reg;
                    em_b_next[1] = {2'b10, val_reg[5:0]};
                    em_b_next[2] = {2'b10, val_reg[5:0]};
                    em_b_next[3] = {2'b10, val_reg[5:0]};
                    if (is_amp || is_lt || is_gt || is_quot || is_apos)
                    begin
                        em_len_next = EM_W'(1);
                        em_b_next[0] = is_amp ? CH_AMP : is_lt ? CH_LT : is_gt ? CH_GT :
                                       is_quot ? CH_QUOT : CH_APOS;
                    end
                    else if (is_num && num_ok)
                    begin
                        if (val_reg < 21'h80)
                        begin
                            em_len_next  = EM_W'(1);
                            em_b_next[0] = val_reg[7:0];
                        end
                        else if (val_reg < 21'h800)
                        begin
                            em_len_next  = EM_W'(2);
                            em_b_next[0] = {3'b110, val_reg[10:6]};
                        end
                        else if (val_reg < 21'h10000)
                        begin
                            em_len_next  = EM_W'(3);
                            em_b_next[0] = {4'b1110, val_reg[15:12]};
                            em_b_next[1] = {2'b10, val_reg[11:6]};
                        end
                        else
                        begin
                            em_len_next  = EM_W'(4);
                            em_b_next[0] = {5'b11110, val_reg[20:18]};
                            em_b_next[1] = {2'b10, val_reg[17:12]};
                            em_b_next[2] = {2'b10, val_reg[11:6]};
                        end
                    end
                    else
                    begin
                        em_lit_next  = 1'b1;
                        em_len_next  = EM_W'(cnt_reg) + EM_W'(2);
                        em_b_next[0] = CH_AMP;
                    end
                end
                else if (cnt_reg < CNT_W'(WINDOW - 1))
                begin
                    // Hold the byte and advance the digit parse.
                    held_next[cnt_reg] = head;
                    cnt_next           = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        hex_next = hex_use;
                    end
                    if (cnt_reg != CNT_W'(0) && !stop_reg
                        && !(cnt_reg == CNT_W'(1) && hex_use))
                    begin
                        if (dv[4])
                        begin
                            dig_next = 1'b1;
                            val_next = (prod > 25'(CP_SAT)) ? CP_SAT : prod[20:0];
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // Window overflow: emit '&' and rescan the held bytes.
                    emit_req  = 1'b1;
                    emit_byte = CH_AMP;
                    for (int i = 0; i < WINDOW; i++)
                    begin
                        if (i < int'(cnt_reg))
                        begin
                            pq_next[i] = held_reg[i];
                        end
                        else if (i == int'(cnt_reg))
                        begin
                            pq_next[i] = head;
                        end
                    end
                    pq_len_next = LEN_W'(cnt_reg) + LEN_W'(1);
                    in_ent_next = 1'b0;
                    cnt_next    = '0;
                end
            end
            else if (end_reg && in_ent_reg)
            begin
                // End of text with an open entity: release it and rescan.
                emit_req  = 1'b1;
                emit_byte = CH_AMP;
                for (int i = 0; i < WINDOW; i++)
                begin
                    pq_next[i] = held_reg[i];
                end
                pq_len_next = LEN_W'(cnt_reg);
                in_ent_next = 1'b0;
                cnt_next    = '0;
            end
            else
            begin
                finish    = 1'b1;
                busy_next = 1'b0;
                ocnt_next = '0;
            end

            // Results beyond the per-transaction limit are dropped.
            if (emit_req && ocnt_reg < OC_W'(MAX_RES))
            begin
                ocnt_next = ocnt_reg + OC_W'(1);
                if (pend_v_reg)
                begin
                    push.valid           = 1'b1;
                    push.item.plain_byte = pend_b_reg;
                    push.item.run_last   = 1'b0;
                end
                pend_v_next = 1'b1;
                pend_b_next = emit_byte;
            end
            else if (finish && pend_v_reg)
            begin
                push.valid           = 1'b1;
                push.item.plain_byte = pend_b_reg;
                push.item.run_last   = 1'b1;
                pend_v_next          = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pq_len_reg <= '0;
            cnt_reg    <= '0;
            in_ent_reg <= 1'b0;
            end_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            em_act_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            ocnt_reg   <= '0;
        end
        else
        begin
            pq_len_reg <= pq_len_next;
            cnt_reg    <= cnt_next;
            in_ent_reg <= in_ent_next;
            end_reg    <= end_next;
            busy_reg   <= busy_next;
            em_act_reg <= em_act_next;
            pend_v_reg <= pend_v_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    // Payload and datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        pq_reg      <= pq_next;
        held_reg    <= held_next;
        hex_reg     <= hex_next;
        dig_reg     <= dig_next;
        stop_reg    <= stop_next;
        val_reg     <= val_next;
        em_lit_reg  <= em_lit_next;
        em_idx_reg  <= em_idx_next;
        em_len_reg  <= em_len_next;
        em_b_reg    <= em_b_next;
        lit_n_reg   <= lit_n_next;
        pend_b_reg  <= pend_b_next;
    end

    `XEC_ASSERT(a_idle_no_hold, (!in_ent_reg) |-> (cnt_reg == '0), "bytes held outside entity")
    `XEC_ASSERT(a_push_space, push.valid |-> out_space, "push into full output queue")
    `XEC_ASSERT(a_emit_closed, em_act_reg |-> !in_ent_reg, "entity open while emitting")

endmodule
`default_nettype wire

// ----- rtl/xml_entity_unescape_core.sv -----
// XML entity and character reference decoder.
// text_in carries one raw byte per transaction with text_end marking the
// last byte of a text; plain_out carries unescaped bytes, and run_last marks
// the last result byte caused by one input transaction (an input that only
// opens or extends an entity gives no result).
// A two-entry input queue feeds the decoding engine, which works on one input
// transaction at a time in steps: it loads the transaction, scans each byte,
// emits each result of a resolved entity in turn and then closes the run.
// On a window overflow the held bytes and the overflowing byte are all
// scanned again; end of text with an open entity releases the '&' and
// rescans the held bytes.
// Results pass through a two-entry output queue; while the receiver stalls
// and that queue is full the engine holds, and once the input queue is full
// text_in.ready falls. Nothing is lost.
// Reset (rst_n low, asynchronous) empties both queues and closes any open
// entity; the hold buffer needs no clearing.
`default_nettype none
module xml_entity_unescape_core (
    input  wire logic clk,
    input  wire logic rst_n,
    xec_in_if.sink    text_in,
    xec_out_if.source plain_out
);
    import xec_pkg::*;

    in_item_t item;
    logic     item_valid;
    logic     item_pop;
    logic     out_space;
    push_t    push;

    xec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    xec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .out_space  (out_space),
        .push       (push)
    );

    xec_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (out_space),
        .plain_out (plain_out)
    );

endmodule
`default_nettype wire
